// ----- sv/text_cell_glyph_rasterizer_top_assert.svh -----
// ----------------------------------------------------------------------------
// Text cell glyph rasterizer assertion macros
// Shared property forms for the checkers of the rasterizer. They expect
// signals named clk and arst_n in the scope where they are used.
// ----------------------------------------------------------------------------
`ifndef TEXT_CELL_GLYPH_RASTERIZER_TOP_ASSERT_SVH
`define TEXT_CELL_GLYPH_RASTERIZER_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TCGR_ASSERT_NOW(lbl, ante, cons) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("tcgr assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define TCGR_ASSERT_NEXT(lbl, ante, cons) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("tcgr assertion failed");

`endif

// ----- sv/tcgr_pkg.sv -----
// ----------------------------------------------------------------------------
// Text cell glyph rasterizer package
// Word types of both channels, the command word of the internal queue and
// the fixed codes and widths shared by the modules.
// ----------------------------------------------------------------------------
package tcgr_pkg;

	localparam int ADDR_W      = 23;
	localparam int COLORS_W    = 64;
	localparam int COUNT_W     = 4;
	localparam int MAX_PIXELS  = 8;
	localparam int FONT_AW_MAX = 12;
	localparam int RROW_W      = 12;
	localparam int RROWX_W     = 15;
	localparam int COLOFF_W    = 11;
	localparam int QUEUE_DEPTH = 4;

	localparam logic ACT_RENDER = 1'b0;
	localparam logic ACT_LOAD   = 1'b1;

	localparam logic [1:0] REG_TEXT_COLUMNS = 2'd0;
	localparam logic [1:0] REG_TEXT_LINES   = 2'd1;
	localparam logic [1:0] REG_SHRINK_POWER = 2'd2;

	localparam logic [7:0] TEXT_COLUMNS_RESET = 8'd80;
	localparam logic [7:0] TEXT_LINES_RESET   = 8'd25;
	localparam logic [1:0] SHRINK_POWER_RESET = 2'd0;

	// Glyph scan step that underline forces to the foreground color.
	localparam int UL_SCAN_STEP = 2;

	typedef struct packed {
		logic       action;
		logic [7:0] cell_column;
		logic [7:0] cell_row;
		logic [7:0] char_code;
		logic [7:0] fore_color;
		logic [7:0] back_color;
		logic       underline;
		logic [3:0] glyph_row_index;
		logic [7:0] glyph_row_bits;
	} item_t;

	typedef struct packed {
		logic [ADDR_W-1:0]   pixel_address;
		logic [COLORS_W-1:0] pixel_colors;
		logic [COUNT_W-1:0]  pixel_count;
		logic                last;
	} result_t;

	// One classified word for the back end: either a font write or a cell.
	typedef struct packed {
		logic                   is_load;
		logic                   code_ok;
		logic [FONT_AW_MAX-1:0] font_addr;
		logic [7:0]             glyph_bits;
		logic [RROW_W-1:0]      rrow0;
		logic [COLOFF_W-1:0]    col_off;
		logic [7:0]             fore_color;
		logic [7:0]             back_color;
		logic                   underline;
	} cmd_t;

endpackage

// ----- sv/tcgr_front.sv -----
// ----------------------------------------------------------------------------
// Text cell glyph rasterizer front end
// Classifies an incoming word, drops what produces nothing and precomputes
// the per-cell address terms for the back end.
// ----------------------------------------------------------------------------
module tcgr_front import tcgr_pkg::*; #(
	parameter int GLYPH_WIDTH  = 8,
	parameter int GLYPH_HEIGHT = 16,
	parameter int GLYPH_COUNT  = 256
) (
	input  item_t      item,
	input  logic [7:0] text_columns,
	input  logic [7:0] text_lines,
	input  logic [1:0] shrink_power,
	output cmd_t       cmd,
	output logic       keep
);

	logic                   code_ok;
	logic                   row_ok;
	logic                   in_bounds;
	logic [7:0]             lines_left;
	logic [12:0]            rrow_full;
	logic [COLOFF_W-1:0]    col_full;
	logic [FONT_AW_MAX-1:0] glyph_base;

	always_comb begin
		code_ok    = 9'(item.char_code) < 9'(GLYPH_COUNT);
		row_ok     = 5'(item.glyph_row_index) < 5'(GLYPH_HEIGHT);
		in_bounds  = (item.cell_column < text_columns) && (item.cell_row < text_lines);
		// Raster rows are stored bottom-up, so the top text line lands last.
		lines_left = text_lines - item.cell_row - 8'd1;
		rrow_full  = (13'(lines_left) * 13'(GLYPH_HEIGHT)) >> shrink_power;
		col_full   = (COLOFF_W'(item.cell_column) * COLOFF_W'(GLYPH_WIDTH)) >> shrink_power;
		glyph_base = FONT_AW_MAX'(item.char_code) * FONT_AW_MAX'(GLYPH_HEIGHT);

		cmd.is_load    = (item.action == ACT_LOAD);
		cmd.code_ok    = code_ok;
		cmd.font_addr  = (item.action == ACT_LOAD)
			? glyph_base + FONT_AW_MAX'(item.glyph_row_index) : glyph_base;
		cmd.glyph_bits = item.glyph_row_bits;
		cmd.rrow0      = RROW_W'(rrow_full);
		cmd.col_off    = col_full;
		cmd.fore_color = item.fore_color;
		cmd.back_color = item.back_color;
		cmd.underline  = item.underline;

		keep = (item.action == ACT_LOAD) ? (code_ok && row_ok) : in_bounds;
	end

endmodule

// ----- sv/tcgr_queue.sv -----
// ----------------------------------------------------------------------------
// Text cell glyph rasterizer command queue
// Short first-in first-out buffer that decouples the front end from the
// row sequencer.
// ----------------------------------------------------------------------------
module tcgr_queue import tcgr_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	output logic push_ready,
	input  logic pop,
	output cmd_t head,
	output logic head_valid
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);

	cmd_t           slots_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [PTR_W:0]   fill_q;

	assign push_ready = fill_q != (PTR_W+1)'(QUEUE_DEPTH);
	assign head_valid = fill_q != '0;
	assign head       = slots_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

// ----- sv/tcgr_back.sv -----
// ----------------------------------------------------------------------------
// Text cell glyph rasterizer back end
// Owns the font memory. Writes font rows; steps the kept glyph rows of a
// cell one per cycle, unless stalled, into a read stage and output register.
// ----------------------------------------------------------------------------
module tcgr_back import tcgr_pkg::*; #(
	parameter int GLYPH_WIDTH  = 8,
	parameter int GLYPH_HEIGHT = 16,
	parameter int GLYPH_COUNT  = 256
) (
	input  logic       clk,
	input  logic       arst_n,
	input  cmd_t       head,
	input  logic       head_valid,
	output logic       pop,
	input  logic [7:0] text_columns,
	input  logic [1:0] shrink_power,
	output result_t    result,
	output logic       result_valid,
	input  logic       result_ready
);

	localparam int FONT_DEPTH = GLYPH_COUNT * GLYPH_HEIGHT;
	localparam int FONT_AW    = $clog2(FONT_DEPTH);
	localparam int ROW_W      = $clog2(GLYPH_HEIGHT);
	localparam int PY_W       = ROW_W + 3;

	logic [7:0] font_mem [FONT_DEPTH];

	cmd_t             cur_q;
	logic             active_q;
	logic [ROW_W-1:0] row_q;

	logic                s1_valid;
	logic [7:0]          rd_s1;
	logic                code_ok_s1;
	logic                force_s1;
	logic                last_s1;
	logic [7:0]          fg_s1;
	logic [7:0]          bg_s1;
	logic [RROWX_W-1:0]  rroww_s1;
	logic [COLOFF_W-1:0] coloff_s1;

	result_t result_q;
	logic    result_valid_q;

	logic               out_ok;
	logic               s1_ready;
	logic               issue;
	logic               row_last;
	logic               done;
	logic [ROW_W-1:0]   last_row;
	logic [PY_W-1:0]    py_w;
	logic [FONT_AW-1:0] raddr;
	logic [RROW_W-1:0]  rrow;
	logic [RROWX_W-1:0] rroww;
	logic               force_on;
	result_t            result_d;

	always_comb begin
		out_ok   = !result_valid_q || result_ready;
		s1_ready = !s1_valid || out_ok;
		last_row = ROW_W'(((GLYPH_HEIGHT + (1 << shrink_power) - 1) >> shrink_power) - 1);
		row_last = row_q == last_row;
		issue    = active_q && !cur_q.is_load && s1_ready;
		done     = active_q && (cur_q.is_load || (issue && row_last));
		pop      = head_valid && (!active_q || done);

		// Glyph scan step of this row, and the stored row it reads (bottom-up).
		py_w     = {3'b000, row_q} << shrink_power;
		raddr    = FONT_AW'(cur_q.font_addr) + FONT_AW'(GLYPH_HEIGHT - 1) - FONT_AW'(py_w);
		force_on = cur_q.underline && (py_w == PY_W'(UL_SCAN_STEP));
		rrow     = cur_q.rrow0 + RROW_W'(row_q);
		rroww    = RROWX_W'((RROWX_W'(rrow) * RROWX_W'(GLYPH_WIDTH)) >> shrink_power);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q       <= 1'b0;
			row_q          <= '0;
			s1_valid       <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				active_q <= 1'b1;
				row_q    <= '0;
			end else begin
				if (done) begin
					active_q <= 1'b0;
				end
				if (issue) begin
					row_q <= row_q + 1'b1;
				end
			end
			if (s1_ready) begin
				s1_valid <= issue;
			end
			if (out_ok) begin
				result_valid_q <= s1_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= head;
		end
		if (issue) begin
			code_ok_s1 <= cur_q.code_ok;
			force_s1   <= force_on;
			last_s1    <= row_last;
			fg_s1      <= cur_q.fore_color;
			bg_s1      <= cur_q.back_color;
			rroww_s1   <= rroww;
			coloff_s1  <= cur_q.col_off;
		end
		if (out_ok && s1_valid) begin
			result_q <= result_d;
		end
	end

	// Font memory: one write port for loads, one registered read port for rows.
	always_ff @(posedge clk) begin
		if (active_q && cur_q.is_load) begin
			font_mem[FONT_AW'(cur_q.font_addr)] <= cur_q.glyph_bits;
		end
		if (issue) begin
			rd_s1 <= font_mem[raddr];
		end
	end

	always_comb begin
		logic [7:0]        pattern;
		logic [ADDR_W-1:0] prod;
		logic              on;
		int                px;
		pattern  = code_ok_s1 ? rd_s1 : 8'd0;
		prod     = ADDR_W'(rroww_s1) * ADDR_W'(text_columns);
		result_d.pixel_address = prod + ADDR_W'(coloff_s1);
		result_d.pixel_count   =
			COUNT_W'((GLYPH_WIDTH + (1 << shrink_power) - 1) >> shrink_power);
		result_d.last          = last_s1;
		result_d.pixel_colors  = '0;
		for (int k = 0; k < MAX_PIXELS; k++) begin
			px = k << shrink_power;
			if (px < GLYPH_WIDTH) begin
				on = pattern[GLYPH_WIDTH - 1 - px] | force_s1;
				result_d.pixel_colors[8*k +: 8] = on ? fg_s1 : bg_s1;
			end
		end
	end

	assign result       = result_q;
	assign result_valid = result_valid_q;

endmodule

// ----- sv/text_cell_glyph_rasterizer_top.sv -----
// ----------------------------------------------------------------------------
// Text cell glyph rasterizer
// Renders terminal character cells into an 8-bit indexed bottom-up raster.
// ----------------------------------------------------------------------------
// Input words arrive on item_valid/item_ready. A load word writes one glyph
// row into the font memory and produces nothing; a render word produces one
// result word per kept glyph scan row on result_valid/result_ready, with the
// last flag set on the final row of the cell. Cells outside the configured
// screen and loads outside the font are accepted and dropped.
// The configuration port (cfg_we, cfg_index, cfg_data) sets text_columns,
// text_lines and shrink_power; the user must write it only while the block is
// idle, which the block does not enforce. The front end classifies a word in
// the cycle it is accepted and pushes it into a four-entry queue. The row
// sequencer takes one command at a time: a load writes one font row, a render
// makes ceil(GLYPH_HEIGHT / 2^shrink_power) rows, one font memory read per
// row. A render's first result passes the queue, command register, read stage
// and output register. While the queue has room, input words are accepted
// even while results wait. When the receiver stalls, the output register
// holds its word, the read stage fills, and the sequencer pauses. Reset
// clears the queue, the sequencer and the output; the font memory is not
// cleared and holds no defined content until its rows are loaded.
// ----------------------------------------------------------------------------
module text_cell_glyph_rasterizer_top import tcgr_pkg::*; #(
	parameter int GLYPH_WIDTH  = 8,
	parameter int GLYPH_HEIGHT = 16,
	parameter int GLYPH_COUNT  = 256
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       item_valid,
	output logic       item_ready,
	input  item_t      item,
	output logic       result_valid,
	input  logic       result_ready,
	output result_t    result,
	input  logic       cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [7:0] cfg_data
);

	// Configuration registers. Index three is not decoded and is ignored.
	logic [7:0] text_columns_q;
	logic [7:0] text_lines_q;
	logic [1:0] shrink_power_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			text_columns_q <= TEXT_COLUMNS_RESET;
			text_lines_q   <= TEXT_LINES_RESET;
			shrink_power_q <= SHRINK_POWER_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_TEXT_COLUMNS: text_columns_q <= cfg_data;
				REG_TEXT_LINES:   text_lines_q   <= cfg_data;
				REG_SHRINK_POWER: shrink_power_q <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	// The front end is combinational; the queue absorbs its words.
	cmd_t front_cmd;
	logic front_keep;
	logic q_push;
	logic q_ready;
	logic q_pop;
	cmd_t q_head;
	logic q_valid;

	tcgr_front #(
		.GLYPH_WIDTH (GLYPH_WIDTH),
		.GLYPH_HEIGHT(GLYPH_HEIGHT),
		.GLYPH_COUNT (GLYPH_COUNT)
	) u_front (
		.item        (item),
		.text_columns(text_columns_q),
		.text_lines  (text_lines_q),
		.shrink_power(shrink_power_q),
		.cmd         (front_cmd),
		.keep        (front_keep)
	);

	// Every word is taken while the queue has room; dropped words are not pushed.
	assign item_ready = q_ready;
	assign q_push     = item_valid && q_ready && front_keep;

	tcgr_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_cmd  (front_cmd),
		.push_ready(q_ready),
		.pop       (q_pop),
		.head      (q_head),
		.head_valid(q_valid)
	);

	tcgr_back #(
		.GLYPH_WIDTH (GLYPH_WIDTH),
		.GLYPH_HEIGHT(GLYPH_HEIGHT),
		.GLYPH_COUNT (GLYPH_COUNT)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (q_head),
		.head_valid  (q_valid),
		.pop         (q_pop),
		.text_columns(text_columns_q),
		.shrink_power(shrink_power_q),
		.result      (result),
		.result_valid(result_valid),
		.result_ready(result_ready)
	);

endmodule

// ----- sv/tcgr_checker.sv -----
// ----------------------------------------------------------------------------
// Text cell glyph rasterizer checker
// Watches the result channel of the top level and checks the row sequence.
// ----------------------------------------------------------------------------
`include "text_cell_glyph_rasterizer_top_assert.svh"

module tcgr_checker import tcgr_pkg::*; (
	input logic    clk,
	input logic    arst_n,
	input logic    result_valid,
	input logic    result_ready,
	input result_t result
);

	// A stalled result word holds until taken.
	`TCGR_ASSERT_NEXT(a_result_hold, result_valid && !result_ready, result_valid && $stable(result))

	// Rows of one cell follow each other without a gap once the receiver takes them.
	`TCGR_ASSERT_NEXT(a_rows_contiguous, result_valid && result_ready && !result.last, result_valid)

	// All rows of one cell carry the same pixel count.
	`TCGR_ASSERT_NEXT(a_count_steady, result_valid && result_ready && !result.last, result.pixel_count == $past(result.pixel_count))

	// With one valid pixel, all higher color bytes are zero.
	`TCGR_ASSERT_NOW(a_unused_bytes_zero, result_valid && result.pixel_count == 4'd1, result.pixel_colors[63:8] == 56'd0)

endmodule

bind text_cell_glyph_rasterizer_top tcgr_checker u_tcgr_checker (.*);

// ----- dv/text_cell_glyph_rasterizer_top_tb.sv -----
// ----------------------------------------------------------------------------
// Text cell glyph rasterizer testbench
// Loads glyphs into the font memory and renders cells across several screen
// geometries and shrink factors, under varied sender and receiver pressure.
// A scoreboard class predicts each row word and compares it in order.
// ----------------------------------------------------------------------------
module text_cell_glyph_rasterizer_top_tb import tcgr_pkg::*;;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int GLYPH_W = 8;
	localparam int GLYPH_H = 16;
	localparam int GLYPHS  = 256;

	// Cycles to let the block finish words that produce no results (loads and
	// dropped cells still in the queue) before a register write.
	localparam int SETTLE_CYCLES = 120;
	localparam int CYCLE_LIMIT   = 500000;

	// Predicts the row words of the rasterizer and checks them in order.
	class glyph_raster_scoreboard;
		logic [7:0]  font_rows [GLYPHS*GLYPH_H];
		bit   [15:0] rows_loaded [GLYPHS];
		logic [7:0]  columns = TEXT_COLUMNS_RESET;
		logic [7:0]  lines   = TEXT_LINES_RESET;
		logic [1:0]  shrink  = SHRINK_POWER_RESET;
		result_t     pending_rows [$];
		int unsigned mismatches = 0;

		function void set_screen(logic [7:0] c, logic [7:0] l, logic [1:0] s);
			columns = c;
			lines   = l;
			shrink  = s;
		endfunction

		function int pending();
			return pending_rows.size();
		endfunction

		// A glyph may be rendered only once every one of its rows is loaded.
		function bit glyph_complete(logic [7:0] code);
			return rows_loaded[code] == 16'hFFFF;
		endfunction

		function void note_word(item_t w);
			int unsigned f, py, px, k, rrow, addr, ncol, nline, col, line;
			logic [7:0]  pattern;
			logic        dot;
			result_t     row;
			if (w.action == ACT_LOAD) begin
				font_rows[w.char_code*GLYPH_H + w.glyph_row_index] = w.glyph_row_bits;
				rows_loaded[w.char_code][w.glyph_row_index] = 1'b1;
				return;
			end
			if (w.cell_column >= columns || w.cell_row >= lines)
				return;
			f     = 1 << shrink;
			ncol  = columns;
			nline = lines;
			col   = w.cell_column;
			line  = w.cell_row;
			for (py = 0; py < GLYPH_H; py += f) begin
				// The raster is bottom-up: glyph scan step 0 is the glyph's
				// last stored row and the top text line lands highest.
				pattern = font_rows[w.char_code*GLYPH_H + (GLYPH_H - 1 - py)];
				rrow    = (nline - line - 1) * GLYPH_H / f + py / f;
				addr    = rrow * GLYPH_W / f * ncol + col * GLYPH_W / f;
				row     = '0;
				k       = 0;
				for (px = 0; px < GLYPH_W; px += f) begin
					dot = pattern[GLYPH_W - 1 - px];
					if (w.underline && py == UL_SCAN_STEP)
						dot = 1'b1;
					row.pixel_colors[8*k +: 8] = dot ? w.fore_color : w.back_color;
					k++;
				end
				row.pixel_address = addr[ADDR_W-1:0];
				row.pixel_count   = k[COUNT_W-1:0];
				row.last          = (py + f >= GLYPH_H);
				pending_rows.push_back(row);
			end
		endfunction

		function void check_word(result_t r);
			result_t e;
			if (pending_rows.size() == 0) begin
				$display("%0t: unexpected row word addr=%0h colors=%0h count=%0d last=%0b",
					$time, r.pixel_address, r.pixel_colors, r.pixel_count, r.last);
				mismatches++;
				return;
			end
			e = pending_rows.pop_front();
			if (r.pixel_address !== e.pixel_address) begin
				$display("%0t: pixel_address expected %0h actual %0h",
					$time, e.pixel_address, r.pixel_address);
				mismatches++;
			end
			if (r.pixel_colors !== e.pixel_colors) begin
				$display("%0t: pixel_colors expected %016h actual %016h",
					$time, e.pixel_colors, r.pixel_colors);
				mismatches++;
			end
			if (r.pixel_count !== e.pixel_count) begin
				$display("%0t: pixel_count expected %0d actual %0d",
					$time, e.pixel_count, r.pixel_count);
				mismatches++;
			end
			if (r.last !== e.last) begin
				$display("%0t: last expected %0b actual %0b", $time, e.last, r.last);
				mismatches++;
			end
		endfunction
	endclass

	logic       clk          = 1'b0;
	logic       arst_n       = 1'b0;
	logic       item_valid   = 1'b0;
	logic       item_ready;
	item_t      item         = '0;
	logic       result_valid;
	logic       result_ready = 1'b0;
	result_t    result;
	logic       cfg_we       = 1'b0;
	logic [1:0] cfg_index    = REG_TEXT_COLUMNS;
	logic [7:0] cfg_data     = '0;

	glyph_raster_scoreboard sb = new;

	// Chance in percent that the sender idles or the receiver stalls in a
	// given cycle; each phase of the run picks its own pair.
	int unsigned send_idle_pct = 0;
	int unsigned stall_pct     = 0;
	int unsigned cycle_count   = 0;

	// Character codes whose sixteen rows have all been loaded.
	logic [7:0] loaded_codes [$];

	text_cell_glyph_rasterizer_top i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// The run is cut off if the block hangs or drops a word.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("text_cell_glyph_rasterizer_top_tb NOT OK");
			$finish;
		end
	end

	// Receiver: the values sampled here are those before the edge, so a row
	// word is taken exactly when the block sees valid and ready together. The
	// ready for the next cycle is drawn afterwards from the stall chance.
	always @(posedge clk) begin
		if (arst_n && result_valid && result_ready)
			sb.check_word(result);
		result_ready <= ($urandom_range(99) >= stall_pct);
	end

	// Fills every field with random bits; callers then pin the fields that
	// matter for the word they want. The ignored fields stay random so that
	// every bit of the input word toggles over the run.
	function automatic item_t scrambled_word();
		item_t w;
		w = item_t'({$urandom, $urandom});
		return w;
	endfunction

	// Presents one word and holds it until it is taken. Valid is left high
	// after the handshake so back-to-back words need no extra assignment.
	task automatic send_word(input item_t w);
		while ($urandom_range(99) < send_idle_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item       <= w;
		item_valid <= 1'b1;
		do
			@(posedge clk);
		while (!item_ready);
		sb.note_word(w);
	endtask

	task automatic load_row(input logic [7:0] code, input logic [3:0] index,
	                        input logic [7:0] bits);
		item_t w;
		w                 = scrambled_word();
		w.action          = ACT_LOAD;
		w.char_code       = code;
		w.glyph_row_index = index;
		w.glyph_row_bits  = bits;
		send_word(w);
	endtask

	// Loads all sixteen rows of one glyph with mostly random patterns and
	// now and then a solid or empty row.
	task automatic load_glyph(input logic [7:0] code);
		logic [7:0] bits;
		for (int r = 0; r < GLYPH_H; r++) begin
			case ($urandom_range(7))
				0: bits = 8'h00;
				1: bits = 8'hFF;
				default: bits = 8'($urandom);
			endcase
			load_row(code, 4'(r), bits);
		end
		if (!(code inside {loaded_codes}))
			loaded_codes.push_back(code);
	endtask

	task automatic render_cell(input logic [7:0] col, input logic [7:0] line,
	                           input logic [7:0] code, input logic [7:0] fg,
	                           input logic [7:0] bg, input logic ul);
		item_t w;
		w             = scrambled_word();
		w.action      = ACT_RENDER;
		w.cell_column = col;
		w.cell_row    = line;
		w.char_code   = code;
		w.fore_color  = fg;
		w.back_color  = bg;
		w.underline   = ul;
		send_word(w);
	endtask

	// Stops the sender and waits until every predicted row word has arrived.
	task automatic drain();
		item_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	// Register writes happen only with the block idle. The three writes go
	// out on consecutive edges and the enable drops once at the end.
	task automatic set_screen(input logic [7:0] c, input logic [7:0] l,
	                          input logic [1:0] s);
		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= REG_TEXT_COLUMNS;
		cfg_data  <= c;
		@(posedge clk);
		cfg_index <= REG_TEXT_LINES;
		cfg_data  <= l;
		@(posedge clk);
		cfg_index <= REG_SHRINK_POWER;
		cfg_data  <= {6'b0, s};
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_screen(c, l, s);
	endtask

	// Random traffic: mostly cells inside the screen drawn from loaded glyphs,
	// with fresh glyph loads, single-row overwrites, stray partial loads and
	// cells outside the screen mixed in. Cells near the screen edges and the
	// first and last columns and lines get extra weight.
	task automatic run_random(input int unsigned n_words);
		int unsigned sent;
		int unsigned pick;
		logic [7:0]  col, line, code;
		sent = 0;
		while (sent < n_words) begin
			pick = $urandom_range(99);
			if (loaded_codes.size() == 0 || pick < 3) begin
				load_glyph(8'($urandom));
				sent += GLYPH_H;
			end else if (pick < 7) begin
				code = loaded_codes[$urandom_range(loaded_codes.size() - 1)];
				load_row(code, 4'($urandom), 8'($urandom));
				sent++;
			end else if (pick < 9) begin
				// A stray row of some glyph; harmless, since a glyph is only
				// rendered once it has been loaded completely.
				load_row(8'($urandom), 4'($urandom), 8'($urandom));
				sent++;
			end else if (pick < 24) begin
				col  = 8'($urandom);
				line = 8'($urandom);
				if ($urandom_range(1))
					col = 8'($urandom_range(255, sb.columns));
				else
					line = 8'($urandom_range(255, sb.lines));
				render_cell(col, line, 8'($urandom), 8'($urandom), 8'($urandom),
					1'($urandom));
				sent++;
			end else begin
				case ($urandom_range(7))
					0: col = 8'd0;
					1: col = sb.columns - 8'd1;
					default: col = 8'($urandom_range(sb.columns - 1));
				endcase
				case ($urandom_range(7))
					0: line = 8'd0;
					1: line = sb.lines - 8'd1;
					default: line = 8'($urandom_range(sb.lines - 1));
				endcase
				code = loaded_codes[$urandom_range(loaded_codes.size() - 1)];
				render_cell(col, line, code, 8'($urandom), 8'($urandom), 1'($urandom));
				sent++;
			end
		end
	endtask

	task automatic set_pressure(input int unsigned mode);
		case (mode)
			0: begin send_idle_pct = 0;  stall_pct = 0;  end
			1: begin send_idle_pct = 88; stall_pct = 0;  end
			2: begin send_idle_pct = 0;  stall_pct = 88; end
			default: begin send_idle_pct = 34; stall_pct = 34; end
		endcase
	endtask

	initial begin
		// Reset is held and then released on a rising edge.
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part at the reset geometry of 80 by 25 with no shrink.
		// One glyph gets empty, solid and single-pixel rows at both ends.
		set_pressure(0);
		load_row(8'h5A, 4'd0, 8'h00);
		load_row(8'h5A, 4'd1, 8'hFF);
		load_row(8'h5A, 4'd2, 8'h80);
		load_row(8'h5A, 4'd3, 8'h01);
		for (int r = 4; r < GLYPH_H; r++)
			load_row(8'h5A, 4'(r), 8'($urandom));
		loaded_codes.push_back(8'h5A);
		// Top-left and bottom-right cells with color extremes, underline on
		// and off, then cells past the last column, past the last line and
		// at the largest coordinates, which must all be dropped.
		render_cell(8'd0, 8'd0, 8'h5A, 8'h00, 8'hFF, 1'b0);
		render_cell(8'd79, 8'd24, 8'h5A, 8'hFF, 8'h00, 1'b1);
		render_cell(8'd80, 8'd0, 8'h5A, 8'h12, 8'h34, 1'b0);
		render_cell(8'd0, 8'd25, 8'h5A, 8'h56, 8'h78, 1'b1);
		render_cell(8'd255, 8'd255, 8'hFF, 8'h9A, 8'hBC, 1'b0);
		render_cell(8'd40, 8'd12, 8'h5A, 8'hA5, 8'h5A, 1'b1);
		run_random(30);

		// Smallest screen with the largest shrink: one cell, two rows each,
		// so the underline step is never kept.
		set_screen(8'd1, 8'd1, 2'd3);
		set_pressure(1);
		run_random(40);

		// Largest screen, which drives the address close to its full width.
		// Half way through the sender holds off until the block is empty.
		set_screen(8'd255, 8'd255, 2'd1);
		set_pressure(2);
		run_random(20);
		drain();
		run_random(25);

		set_screen(8'd37, 8'd9, 2'd2);
		set_pressure(3);
		run_random(40);

		set_screen(8'd255, 8'd1, 2'd0);
		set_pressure(0);
		run_random(40);

		set_screen(8'd1, 8'd255, 2'd3);
		set_pressure(1);
		run_random(40);

		set_screen(TEXT_COLUMNS_RESET, TEXT_LINES_RESET, SHRINK_POWER_RESET);
		set_pressure(3);
		run_random(40);

		// Let the last rows arrive, then give the block time to show any
		// stray word before the verdict.
		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending() == 0) begin
			$display("text_cell_glyph_rasterizer_top_tb OK");
		end else begin
			$display("text_cell_glyph_rasterizer_top_tb NOT OK");
		end
		$finish;
	end

endmodule

// ----- text_cell_glyph_rasterizer_top.f -----
+incdir+sv
sv/tcgr_pkg.sv
sv/tcgr_front.sv
sv/tcgr_queue.sv
sv/tcgr_back.sv
sv/text_cell_glyph_rasterizer_top.sv
sv/tcgr_checker.sv
dv/text_cell_glyph_rasterizer_top_tb.sv
